// ----- sv/fgr_pkg.sv -----
// Shared types, constants and helper functions of the Fourier grid resize remapper.
// Used by fgr_pos_ctr and fourier_grid_resize_remap; depends on nothing else.
`default_nettype none

package fgr_pkg;

  localparam int unsigned MaxDim = 1024;
  localparam int unsigned DimW   = 11;
  localparam int unsigned PosW   = 10;
  localparam int unsigned DataW  = 64;
  localparam int unsigned IdxW   = 30;
  localparam int unsigned SpanW  = PosW + DimW;
  localparam int unsigned ProdW  = PosW + SpanW;
  localparam int unsigned CfgAw  = 3;

  typedef enum logic [CfgAw-1:0] {
    CfgSrcX = 3'd0,
    CfgSrcY = 3'd1,
    CfgSrcZ = 3'd2,
    CfgDstX = 3'd3,
    CfgDstY = 3'd4,
    CfgDstZ = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DataW-1:0] real_bits;
    logic [DataW-1:0] imag_bits;
  } in_t;

  typedef struct packed {
    logic             write_enable;
    logic [IdxW-1:0]  dst_index;
    logic [DataW-1:0] real_out;
    logic [DataW-1:0] imag_out;
    logic             grid_done;
  } out_t;

  typedef struct packed {
    logic [DimW-1:0] sx;
    logic [DimW-1:0] sy;
    logic [DimW-1:0] sz;
    logic [DimW-1:0] dx;
    logic [DimW-1:0] dy;
    logic [DimW-1:0] dz;
  } size_t;

  typedef struct packed {
    logic            keep;
    logic [PosW-1:0] px;
    logic [PosW-1:0] ty;
    logic [PosW-1:0] tz;
    logic            done;
  } pos_info_t;

  typedef struct packed {
    logic            ok;
    logic [PosW-1:0] pos;
  } axis_map_t;

  function automatic logic [DimW-1:0] eff_size(logic [DimW-1:0] v, logic [DimW-1:0] lo);
    logic [DimW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic axis_map_t map_axis(logic [PosW-1:0] p, logic [DimW-1:0] s,
                                         logic [DimW-1:0] d);
    logic [DimW-1:0] m;
    logic [DimW-1:0] h;
    logic [DimW-1:0] sm;
    logic [DimW-1:0] dm;
    logic [DimW:0]   lim;
    logic [DimW:0]   t;
    axis_map_t       r;
    m      = (s < d) ? s : d;
    h      = m >> 1;
    sm     = s - m;
    dm     = d - m;
    lim    = {1'b0, h} + {1'b0, sm};
    t      = {2'b00, p} - {1'b0, sm} + {1'b0, dm};
    r.ok   = 1'b0;
    r.pos  = '0;
    if ({1'b0, p} >= s) begin
      r.ok = 1'b0;
    end else if ({1'b0, p} < h) begin
      r.ok  = 1'b1;
      r.pos = p;
    end else if ({2'b00, p} >= lim) begin
      r.ok  = 1'b1;
      r.pos = t[PosW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fgr_pos_ctr.sv -----
// Source position counters and per-axis survival mapping of the grid remapper.
// Depends on fgr_pkg for sizes, position info type and the axis mapping function.
`default_nettype none

module fgr_pos_ctr (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire fgr_pkg::size_t    size_i,
  output fgr_pkg::pos_info_t     info_o
);

  logic [fgr_pkg::PosW-1:0] pos_x_q, pos_x_d;
  logic [fgr_pkg::PosW-1:0] pos_y_q, pos_y_d;
  logic [fgr_pkg::PosW-1:0] pos_z_q, pos_z_d;
  logic [fgr_pkg::DimW-1:0] sxh;
  logic [fgr_pkg::DimW-1:0] mx;
  logic [fgr_pkg::DimW-1:0] kx;
  logic                     last_x, last_y, last_z;
  fgr_pkg::axis_map_t       map_y, map_z;

  assign sxh    = (size_i.sx >> 1) + fgr_pkg::DimW'(1);
  assign mx     = (size_i.sx < size_i.dx) ? size_i.sx : size_i.dx;
  assign kx     = (mx >> 1) + fgr_pkg::DimW'(1);
  assign last_x = ({1'b0, pos_x_q} + fgr_pkg::DimW'(1)) >= sxh;
  assign last_y = ({1'b0, pos_y_q} + fgr_pkg::DimW'(1)) >= size_i.sy;
  assign last_z = ({1'b0, pos_z_q} + fgr_pkg::DimW'(1)) >= size_i.sz;
  assign map_y  = fgr_pkg::map_axis(pos_y_q, size_i.sy, size_i.dy);
  assign map_z  = fgr_pkg::map_axis(pos_z_q, size_i.sz, size_i.dz);

  assign info_o.keep = ({1'b0, pos_x_q} < kx) && map_y.ok && map_z.ok;
  assign info_o.px   = pos_x_q;
  assign info_o.ty   = map_y.pos;
  assign info_o.tz   = map_z.pos;
  assign info_o.done = last_x && last_y && last_z;

  always_comb begin
    pos_x_d = pos_x_q + fgr_pkg::PosW'(1);
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (last_x) begin
      pos_x_d = '0;
      pos_y_d = pos_y_q + fgr_pkg::PosW'(1);
      if (last_y) begin
        pos_y_d = '0;
        pos_z_d = last_z ? '0 : pos_z_q + fgr_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (adv_i) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fourier_grid_resize_remap.sv -----
// Top level of the Fourier grid resize remapper: size registers and two-stage pipeline.
// Depends on fgr_pkg and fgr_pos_ctr.
`default_nettype none

// Streams half-complex 3D grid coefficients in source order (x fastest) and tags each
// with a write flag and its index in the resized destination grid; data passes through.
// One coefficient is taken every cycle unless stalled; each passes the first stage,
// then the output register. The first stage maps the position and forms y + dy*z, the
// second stage multiplies by the x row length and adds x. Both stages stall together
// on output back-pressure. Write sizes only while no result is pending; counters are
// untouched by size writes and return to zero after the transfer that flags grid_done.
module fourier_grid_resize_remap (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fgr_pkg::CfgAw-1:0]   cfg_addr_i,
  input  wire logic [fgr_pkg::DimW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire fgr_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output fgr_pkg::out_t                    out_data_o
);

  typedef struct packed {
    logic                      keep;
    logic [fgr_pkg::PosW-1:0]  px;
    logic [fgr_pkg::SpanW-1:0] span;
    logic                      done;
    fgr_pkg::in_t              data;
  } s1_t;

  fgr_pkg::size_t             size_q;
  fgr_pkg::size_t             eff;
  fgr_pkg::pos_info_t         info;
  s1_t                        s1_q, s1_d;
  logic                       s1_valid_q;
  logic                       out_valid_q;
  fgr_pkg::out_t              out_q, out_d;
  logic                       s1_adv;
  logic                       in_xfer;
  logic [fgr_pkg::SpanW-1:0]  prod_y;
  logic [fgr_pkg::PosW-1:0]   dxh;
  logic [fgr_pkg::ProdW-1:0]  prod_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q.sx <= fgr_pkg::DimW'(64);
      size_q.sy <= fgr_pkg::DimW'(64);
      size_q.sz <= fgr_pkg::DimW'(64);
      size_q.dx <= fgr_pkg::DimW'(64);
      size_q.dy <= fgr_pkg::DimW'(64);
      size_q.dz <= fgr_pkg::DimW'(64);
    end else if (cfg_we_i) begin
      case (fgr_pkg::cfg_reg_e'(cfg_addr_i))
        fgr_pkg::CfgSrcX: size_q.sx <= cfg_wdata_i;
        fgr_pkg::CfgSrcY: size_q.sy <= cfg_wdata_i;
        fgr_pkg::CfgSrcZ: size_q.sz <= cfg_wdata_i;
        fgr_pkg::CfgDstX: size_q.dx <= cfg_wdata_i;
        fgr_pkg::CfgDstY: size_q.dy <= cfg_wdata_i;
        fgr_pkg::CfgDstZ: size_q.dz <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign eff.sx = fgr_pkg::eff_size(size_q.sx, fgr_pkg::DimW'(2));
  assign eff.sy = fgr_pkg::eff_size(size_q.sy, fgr_pkg::DimW'(1));
  assign eff.sz = fgr_pkg::eff_size(size_q.sz, fgr_pkg::DimW'(1));
  assign eff.dx = fgr_pkg::eff_size(size_q.dx, fgr_pkg::DimW'(2));
  assign eff.dy = fgr_pkg::eff_size(size_q.dy, fgr_pkg::DimW'(1));
  assign eff.dz = fgr_pkg::eff_size(size_q.dz, fgr_pkg::DimW'(1));

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  fgr_pos_ctr u_pos_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_xfer),
    .size_i (eff),
    .info_o (info)
  );

  assign prod_y    = fgr_pkg::SpanW'(eff.dy) * fgr_pkg::SpanW'(info.tz);
  assign s1_d.keep = info.keep;
  assign s1_d.px   = info.px;
  assign s1_d.span = prod_y + fgr_pkg::SpanW'(info.ty);
  assign s1_d.done = info.done;
  assign s1_d.data = in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
  end

  assign dxh    = fgr_pkg::PosW'((eff.dx >> 1) + fgr_pkg::DimW'(1));
  assign prod_x = fgr_pkg::ProdW'(dxh) * fgr_pkg::ProdW'(s1_q.span)
                + fgr_pkg::ProdW'(s1_q.px);

  assign out_d.write_enable = s1_q.keep;
  assign out_d.dst_index    = s1_q.keep ? prod_x[fgr_pkg::IdxW-1:0] : '0;
  assign out_d.real_out     = s1_q.data.real_bits;
  assign out_d.imag_out     = s1_q.data.imag_bits;
  assign out_d.grid_done    = s1_q.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_drop_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.write_enable |-> out_q.dst_index == '0)
    else $error("dropped coefficient carries a nonzero index");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("first stage lost or changed an item under stall");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !s1_valid_q |=> !out_valid_q)
    else $error("result appeared without a pending item");

endmodule

`default_nettype wire
